// File: hdl/mlqs_pkg.sv
// Shared types, request and status codes, and default sizes for the multilevel queue scheduler.
package mlqs_pkg;

  localparam int DEF_NUM_LEVELS = 4;
  localparam int DEF_NUM_PROCS  = 64;

  localparam int REQ_W    = 3;
  localparam int LEVEL_W  = 2;
  localparam int PID_W    = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE = 3'd0,
    REQ_PICK    = 3'd1,
    REQ_BOOST   = 3'd2,
    REQ_DROP    = 3'd3,
    REQ_MARK    = 3'd4
  } mlqs_req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } mlqs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CHECK
  } mlqs_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [LEVEL_W-1:0] level;
    logic [PID_W-1:0]   proc_id;
  } mlqs_in_t;

  typedef struct packed {
    logic                granted;
    logic [PID_W-1:0]    chosen_id;
    logic [LEVEL_W-1:0]  chosen_level;
    logic [STATUS_W-1:0] status;
  } mlqs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request
    logic exec_simple; // carry out enqueue, drop, mark or no-op and finish
    logic lvl_first;   // start the level walk
    logic lvl_next;    // move to the next level
    logic pop;         // read and pop the head of the current level
    logic boost_push;  // move the popped entry to level 0 if runnable
    logic fin_grant;   // finish a pick with a grant
    logic fin_empty;   // finish a pick with nothing runnable
    logic fin_boost;   // finish a boost
  } mlqs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pick;
    logic is_boost;
    logic lvl_empty;
    logic lvl_last;
    logic head_ok;
  } mlqs_stat_t;

endpackage

// File: hdl/multilevel_queue_scheduler_top.sv
// Top level of the multilevel queue scheduler: controller and datapath joined.
//
//  Channel   Ports                     Transfer when
//  --------  ------------------------  ------------------------------------
//  request   start, busy, request      start high and busy low at a clock edge
//  result    done, result              done high, for exactly one cycle
//
// Enqueue, drop, mark-idle and unused codes go from the transfer through the
// execute state to the result strobe. A pick spends a scan state on each empty
// level and a scan and a check state on each head it pops. A boost walks the
// levels above 0 and drains each entry through a scan and a check state, as each
// entry needs a registered read through the queue memory's single read port.
// Reset empties every level and clears the runnable bits; the queue memory
// itself needs no clearing. The receiver cannot stall: each result is shown
// once, and busy falls in the cycle it appears, so the next request may
// transfer while it is on the ports.
module multilevel_queue_scheduler_top #(
  parameter int NUM_LEVELS = mlqs_pkg::DEF_NUM_LEVELS,
  parameter int NUM_PROCS  = mlqs_pkg::DEF_NUM_PROCS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mlqs_pkg::mlqs_in_t  request,
  output logic                done,
  output mlqs_pkg::mlqs_out_t result
);

  // Command and status bundles between the controller and the datapath.
  mlqs_pkg::mlqs_cmd_t  cmd;
  mlqs_pkg::mlqs_stat_t stat;

  // The controller drives busy, accepts start and sequences the level walks.
  mlqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds all queue state and registers the result.
  mlqs_dp #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_PROCS  (NUM_PROCS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// File: hdl/mlqs_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module mlqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mlqs_pkg::mlqs_stat_t stat,
  output logic               busy,
  output mlqs_pkg::mlqs_cmd_t  cmd
);

  mlqs_pkg::mlqs_state_t state;
  mlqs_pkg::mlqs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mlqs_pkg::S_IDLE: begin
        if (start) state_next = mlqs_pkg::S_EXEC;
      end
      mlqs_pkg::S_EXEC: begin
        if (stat.is_pick || stat.is_boost) state_next = mlqs_pkg::S_SCAN;
        else state_next = mlqs_pkg::S_IDLE;
      end
      mlqs_pkg::S_SCAN: begin
        if (!stat.lvl_empty) state_next = mlqs_pkg::S_CHECK;
        else if (stat.lvl_last) state_next = mlqs_pkg::S_IDLE;
      end
      mlqs_pkg::S_CHECK: begin
        if (stat.is_boost) state_next = mlqs_pkg::S_SCAN;
        else if (stat.head_ok || stat.lvl_last) state_next = mlqs_pkg::S_IDLE;
        else state_next = mlqs_pkg::S_SCAN;
      end
      default: state_next = mlqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      mlqs_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mlqs_pkg::S_EXEC: begin
        if (stat.is_pick || stat.is_boost) cmd.lvl_first = 1'b1;
        else cmd.exec_simple = 1'b1;
      end
      mlqs_pkg::S_SCAN: begin
        if (!stat.lvl_empty) begin
          cmd.pop = 1'b1;
        end else if (!stat.lvl_last) begin
          cmd.lvl_next = 1'b1;
        end else begin
          cmd.fin_boost = stat.is_boost;
          cmd.fin_empty = !stat.is_boost;
        end
      end
      mlqs_pkg::S_CHECK: begin
        if (stat.is_boost) begin
          cmd.boost_push = 1'b1;
        end else if (stat.head_ok) begin
          cmd.fin_grant = 1'b1;
        end else if (stat.lvl_last) begin
          cmd.fin_empty = 1'b1;
        end else begin
          cmd.lvl_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/mlqs_dp.sv
// Datapath with the queue memory, head and tail pointers, runnable bits and result register.
module mlqs_dp #(
  parameter int NUM_LEVELS = mlqs_pkg::DEF_NUM_LEVELS,
  parameter int NUM_PROCS  = mlqs_pkg::DEF_NUM_PROCS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlqs_pkg::mlqs_in_t   request,
  input  mlqs_pkg::mlqs_cmd_t  cmd,
  output mlqs_pkg::mlqs_stat_t stat,
  output logic                 done,
  output mlqs_pkg::mlqs_out_t  result
);

  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int PTR_W     = $clog2(NUM_PROCS);
  localparam int ADDR_W    = LVL_W + PTR_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  mlqs_pkg::mlqs_in_t             req;
  logic [LVL_W-1:0]               cur_lvl;
  logic [PTR_W-1:0]               head [NUM_LEVELS];
  logic [PTR_W-1:0]               tail [NUM_LEVELS];
  logic [NUM_PROCS-1:0]           runnable;
  logic [mlqs_pkg::PID_W-1:0]     mem [MEM_DEPTH];
  logic [mlqs_pkg::PID_W-1:0]     rdata;
  logic                           boost_full;
  mlqs_pkg::mlqs_out_t            result_next;

  logic [LVL_W-1:0]               req_lvl;
  logic                           req_lvl_ok;
  logic                           pid_ok;
  logic [PTR_W-1:0]               pid_idx;
  logic                           is_enq;
  logic                           is_drop;
  logic                           is_mark;
  logic                           enq_ok;
  logic                           drop_ok;
  logic                           head_ok;
  logic                           lvl0_full;
  logic                           push0;
  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [mlqs_pkg::PID_W-1:0]     wr_data;
  logic [ADDR_W-1:0]              rd_addr;
  logic [mlqs_pkg::STATUS_W-1:0]  simple_status;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(NUM_PROCS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign req_lvl    = LVL_W'(req.level);
  assign req_lvl_ok = 32'(req.level) < NUM_LEVELS;
  assign pid_ok     = 32'(req.proc_id) < NUM_PROCS;
  assign pid_idx    = PTR_W'(req.proc_id);

  assign is_enq  = req.req_type == mlqs_pkg::REQ_ENQUEUE;
  assign is_drop = req.req_type == mlqs_pkg::REQ_DROP;
  assign is_mark = req.req_type == mlqs_pkg::REQ_MARK;

  assign enq_ok  = req_lvl_ok && pid_ok && (ptr_inc(tail[req_lvl]) != head[req_lvl]);
  assign drop_ok = req_lvl_ok && (head[req_lvl] != tail[req_lvl]);

  // An entry popped from memory is granted or promoted only if its slot is runnable.
  assign head_ok   = (32'(rdata) < NUM_PROCS) && runnable[PTR_W'(rdata)];
  assign lvl0_full = ptr_inc(tail[0]) == head[0];
  assign push0     = cmd.boost_push && head_ok && !lvl0_full;

  assign wr_en   = (cmd.exec_simple && is_enq && enq_ok) || push0;
  assign wr_addr = push0 ? {LVL_W'(0), tail[0]} : {req_lvl, tail[req_lvl]};
  assign wr_data = push0 ? rdata : req.proc_id;
  assign rd_addr = {cur_lvl, head[cur_lvl]};

  assign stat.is_pick   = req.req_type == mlqs_pkg::REQ_PICK;
  assign stat.is_boost  = req.req_type == mlqs_pkg::REQ_BOOST;
  assign stat.lvl_empty = head[cur_lvl] == tail[cur_lvl];
  assign stat.lvl_last  = cur_lvl == LVL_W'(NUM_LEVELS - 1);
  assign stat.head_ok   = head_ok;

  always_comb begin
    case (req.req_type)
      mlqs_pkg::REQ_ENQUEUE: simple_status = enq_ok ? mlqs_pkg::STAT_OK : mlqs_pkg::STAT_FULL;
      mlqs_pkg::REQ_DROP:    simple_status = drop_ok ? mlqs_pkg::STAT_OK : mlqs_pkg::STAT_EMPTY;
      default:               simple_status = mlqs_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req <= request;
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl_first) begin
      cur_lvl <= stat.is_boost ? LVL_W'(1) : '0;
    end else if (cmd.lvl_next) begin
      cur_lvl <= cur_lvl + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.pop) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      if (cmd.pop) head[cur_lvl] <= ptr_inc(head[cur_lvl]);
      if (cmd.exec_simple && is_drop && drop_ok) head[req_lvl] <= ptr_inc(head[req_lvl]);
      if (cmd.exec_simple && is_enq && enq_ok) tail[req_lvl] <= ptr_inc(tail[req_lvl]);
      if (push0) tail[0] <= ptr_inc(tail[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runnable <= '0;
    end else if (cmd.exec_simple) begin
      if (is_enq && enq_ok) runnable[pid_idx] <= 1'b1;
      if (is_mark && pid_ok) runnable[pid_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_full <= 1'b0;
    end else if (cmd.lvl_first) begin
      boost_full <= 1'b0;
    end else if (cmd.boost_push && head_ok && lvl0_full) begin
      boost_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec_simple || cmd.fin_grant || cmd.fin_empty || cmd.fin_boost;
    end
  end

  always_comb begin
    result_next = '0;
    if (cmd.exec_simple) begin
      result_next.status = simple_status;
    end else if (cmd.fin_grant) begin
      result_next.granted      = 1'b1;
      result_next.chosen_id    = rdata;
      result_next.chosen_level = mlqs_pkg::LEVEL_W'(cur_lvl);
      result_next.status       = mlqs_pkg::STAT_OK;
    end else if (cmd.fin_empty) begin
      result_next.status = mlqs_pkg::STAT_EMPTY;
    end else begin
      result_next.status = boost_full ? mlqs_pkg::STAT_FULL : mlqs_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_simple || cmd.fin_grant || cmd.fin_empty || cmd.fin_boost) begin
      result <= result_next;
    end
  end

endmodule
